/* rtl/multi_channel_square_tone_generator_macros.svh */
// assertion macros for the square tone generator
// uses clk_i and rst_ni of the module that includes this header
`ifndef MULTI_CHANNEL_SQUARE_TONE_GENERATOR_MACROS_SVH
`define MULTI_CHANNEL_SQUARE_TONE_GENERATOR_MACROS_SVH

// property checked on every rising edge outside reset
`define MCSTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition at one edge implies another at the next edge
`define MCSTG_ASSERT_NEXT(lbl, pre, post, msg) \
  `MCSTG_ASSERT(lbl, (pre) |=> (post), msg)

`endif

/* rtl/mcstg_pkg.sv */
// types and command codes for the square tone generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mcstg_pkg;

  // command codes of the input transfer
  typedef enum logic [3:0] {
    CMD_TICK     = 4'd0,
    CMD_TONE     = 4'd1,
    CMD_LATCH    = 4'd2,
    CMD_LATCH_ON = 4'd3,
    CMD_ALL_OFF  = 4'd4,
    CMD_AMP      = 4'd5,
    CMD_FREQ     = 4'd6,
    CMD_OCT      = 4'd7,
    CMD_START    = 4'd8
  } cmd_e;

  // configuration register indexes
  localparam logic REG_PAIRED_MODE = 1'b0;
  localparam logic REG_ACTIVE_CH   = 1'b1;

  localparam logic [3:0] ACTIVE_RST = 4'd2;
  localparam logic [7:0] LATCH_RST  = 8'd128;

  typedef logic signed [4:0]  amp_t;
  typedef logic        [16:0] period_t;
  typedef logic signed [17:0] cnt_t;
  typedef logic        [7:0]  freq_t;
  typedef logic        [2:0]  oct_t;

  localparam period_t PERIOD_RST = 17'd32;
  localparam oct_t    OCT_RST    = 3'd4;

  // per-channel update controls for one command
  typedef struct packed {
    logic    tick;
    logic    stop;
    logic    run_set;
    logic    load_cnt;
    logic    amp_we;
    amp_t    amp_val;
    logic    per_we;
    period_t per_val;
    logic    freq_we;
    freq_t   freq_val;
    logic    oct_we;
    oct_t    oct_val;
  } chan_ctrl_t;

  // per-channel state seen by the command decode
  typedef struct packed {
    amp_t  amp;
    freq_t freq;
    oct_t  oct;
    logic  running;
  } chan_stat_t;

endpackage

`default_nettype wire

/* rtl/mcstg_chan.sv */
// one tone channel: amplitude, period, countdown and output level state
// depends on mcstg_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcstg_chan #(
  parameter mcstg_pkg::amp_t AMP_RST = 5'sd0
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  mcstg_pkg::chan_ctrl_t  ctrl_i,
  output mcstg_pkg::chan_stat_t  stat_o,
  output mcstg_pkg::amp_t        held_d_o,
  output logic                   run_d_o
);
  import mcstg_pkg::*;

  amp_t    amp_q, amp_d;
  period_t per_q, per_d;
  cnt_t    cnt_q, cnt_d;
  logic    run_q, run_d;
  amp_t    held_q, held_d;
  freq_t   freq_q, freq_d;
  oct_t    oct_q, oct_d;
  cnt_t    cnt_dec;

  // next state for the current command
  always_comb begin
    amp_d   = amp_q;
    per_d   = per_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    held_d  = held_q;
    freq_d  = freq_q;
    oct_d   = oct_q;
    cnt_dec = cnt_q - 18'sd8;
    if (ctrl_i.amp_we) begin
      amp_d = ctrl_i.amp_val;
    end
    if (ctrl_i.per_we) begin
      per_d = ctrl_i.per_val;
    end
    if (ctrl_i.freq_we) begin
      freq_d = ctrl_i.freq_val;
    end
    if (ctrl_i.oct_we) begin
      oct_d = ctrl_i.oct_val;
    end
    // tick: count down, reload and flip the level on expiry
    if (ctrl_i.tick && run_q) begin
      cnt_d = cnt_dec;
      if (cnt_dec <= 18'sd0) begin
        cnt_d  = cnt_t'({1'b0, per_q});
        amp_d  = -amp_q;
        held_d = -amp_q;
      end
    end
    // start of an idle channel
    if (ctrl_i.load_cnt) begin
      cnt_d  = cnt_t'({1'b0, per_d});
      held_d = amp_d;
    end
    if (ctrl_i.stop) begin
      run_d = 1'b0;
    end
    if (ctrl_i.run_set) begin
      run_d = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= AMP_RST;
      per_q  <= PERIOD_RST;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      held_q <= '0;
      freq_q <= '0;
      oct_q  <= OCT_RST;
    end else begin
      amp_q  <= amp_d;
      per_q  <= per_d;
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      held_q <= held_d;
      freq_q <= freq_d;
      oct_q  <= oct_d;
    end
  end

  assign stat_o.amp     = amp_q;
  assign stat_o.freq    = freq_q;
  assign stat_o.oct     = oct_q;
  assign stat_o.running = run_q;
  assign held_d_o       = held_d;
  assign run_d_o        = run_d;

endmodule

`default_nettype wire

/* rtl/mcstg_mix.sv */
// left/right level sums and running mask over all channels
// depends on mcstg_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcstg_mix #(
  parameter int unsigned CHANNELS = 8
) (
  input  mcstg_pkg::amp_t [CHANNELS-1:0] held_i,
  input  logic            [CHANNELS-1:0] run_i,
  output logic signed     [6:0]          left_o,
  output logic signed     [6:0]          right_o,
  output logic            [7:0]          mask_o
);
  import mcstg_pkg::*;

  // even channels to the left, odd channels to the right
  always_comb begin
    left_o  = '0;
    right_o = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if ((i % 2) == 1) begin
        right_o = right_o + {{2{held_i[i][4]}}, held_i[i]};
      end else begin
        left_o = left_o + {{2{held_i[i][4]}}, held_i[i]};
      end
    end
  end

  assign mask_o = 8'(run_i);

endmodule

`default_nettype wire

/* rtl/multi_channel_square_tone_generator.sv */
// top level of the multi-channel square tone generator
// depends on mcstg_pkg, mcstg_chan, mcstg_mix and the assertion macro header
//
//   port group  dir  payload
//   s_axis      in   tdata[3:0] cmd, [6:4] channel, [22:7] value
//   m_axis      out  tdata[6:0] left_level, [13:7] right_level, [21:14] running_mask
//   cfg         in   addr 0 paired_mode, addr 1 active_channels
//
// one command per cycle while m_axis does not stall; a result follows its command transfer
// through two registers: the command sits in the input register, and the channel update
// then fills the result register.
// reset loads all channel state to its start values; no clearing sweep.
// a stalled m_axis holds the result; the input register still takes one more command,
// then s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_channel_square_tone_generator_macros.svh"

module multi_channel_square_tone_generator #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // command stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // cmd, channel, value, zero pad
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // left_level, right_level, running_mask, zero pad
  // configuration writes
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_addr_i,
  input  wire  [3:0]  cfg_wdata_i
);
  import mcstg_pkg::*;

  // input register
  logic        in_valid_q;
  cmd_e        cmd_q;
  logic [2:0]  ch_q;
  logic [15:0] val_q;

  // configuration and shared state
  logic        paired_q;
  logic [3:0]  active_q;
  logic [7:0]  latch_q;

  // result register
  logic              out_valid_q;
  logic signed [6:0] left_q;
  logic signed [6:0] right_q;
  logic [7:0]        mask_q;

  logic step;

  chan_ctrl_t           ctrl [CHANNELS];
  chan_stat_t           stat [CHANNELS];
  amp_t  [CHANNELS-1:0] held_d;
  logic  [CHANNELS-1:0] run_d;

  logic signed [6:0] left_d;
  logic signed [6:0] right_d;
  logic [7:0]        mask_d;

  // decode helpers
  logic [3:0] n_live;
  logic [3:0] lo4;
  logic [3:0] hi4;
  logic       tgt_ok;
  logic [3:0] mag;
  amp_t       tone_amp;
  amp_t       amp_w;
  amp_t       lo_amp;
  freq_t      lo_freq;
  oct_t       lo_oct;
  freq_t      fc_src;
  oct_t       oct_src;
  oct_t       oct_new;
  logic [7:0] nn1;
  logic [3:0] shamt;
  logic [8:0] latch_p1;
  logic [8:0] fc_p1;
  logic [11:0] prod;
  period_t    tone_per;
  period_t    latch_per;
  period_t    fo_per;
  logic       tone_stop;
  logic       pair_idle;

  // check helpers
  logic       stalled;
  logic       all_off_step;
  logic       level_ok;

  // handshake: the command moves on when the result register is free
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= cmd_e'(s_axis_tdata[3:0]);
      ch_q  <= s_axis_tdata[6:4];
      val_q <= s_axis_tdata[22:7];
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paired_q <= 1'b1;
      active_q <= ACTIVE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PAIRED_MODE: paired_q <= cfg_wdata_i[0];
        REG_ACTIVE_CH:   active_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // divider latch, zero stored as 128
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= LATCH_RST;
    end else if (step && (cmd_q == CMD_LATCH)) begin
      latch_q <= (val_q[7:0] == 8'd0) ? LATCH_RST : val_q[7:0];
    end
  end

  // shared operands of the command
  always_comb begin
    n_live    = (active_q > 4'(CHANNELS)) ? 4'(CHANNELS) : active_q;
    lo4       = paired_q ? {ch_q, 1'b0} : {1'b0, ch_q};
    hi4       = paired_q ? {ch_q, 1'b1} : {1'b0, ch_q};
    tgt_ok    = hi4 < 4'(CHANNELS);
    mag       = val_q[3:0];
    pair_idle = !stat[0].running;

    // packed tone register
    tone_amp  = (stat[0].running && stat[0].amp[4]) ? -amp_t'({1'b0, mag})
                                                    : amp_t'({1'b0, mag});
    tone_stop = val_q[7] || (mag == 4'd0);
    nn1       = {1'b0, val_q[14:8]} + 8'd1;
    shamt     = {1'b0, val_q[6:4] ^ 3'b111} + 4'd2;
    tone_per  = period_t'(nn1) << shamt;

    // latch based period
    latch_p1  = {1'b0, latch_q} + 9'd1;
    latch_per = {3'b000, latch_p1, 5'b00000};

    // state of the first target channel
    lo_amp  = '0;
    lo_freq = '0;
    lo_oct  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (lo4 == 4'(i)) begin
        lo_amp  = stat[i].amp;
        lo_freq = stat[i].freq;
        lo_oct  = stat[i].oct;
      end
    end
    amp_w   = lo_amp[4] ? -amp_t'({1'b0, mag}) : amp_t'({1'b0, mag});
    oct_new = {1'b0, val_q[1:0] ^ 2'b11} + 3'd1;

    // frequency / octave period
    fc_src  = (cmd_q == CMD_FREQ) ? val_q[7:0] : lo_freq;
    oct_src = (cmd_q == CMD_OCT) ? oct_new : lo_oct;
    fc_p1   = {1'b0, fc_src} + 9'd1;
    prod    = {9'b0, oct_src} * {3'b000, fc_p1};
    fo_per  = {prod, 5'b00000};
  end

  // per-channel controls
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      ctrl[i] = '0;
      if (step) begin
        case (cmd_q)
          CMD_TICK: begin
            ctrl[i].tick = 4'(i) < n_live;
          end
          CMD_TONE: begin
            if (i < 2) begin
              ctrl[i].amp_we  = 1'b1;
              ctrl[i].amp_val = tone_amp;
              if (tone_stop) begin
                ctrl[i].stop = 1'b1;
              end else begin
                ctrl[i].per_we   = 1'b1;
                ctrl[i].per_val  = tone_per;
                ctrl[i].run_set  = 1'b1;
                ctrl[i].load_cnt = pair_idle;
              end
            end
          end
          CMD_LATCH_ON: begin
            if (i < 2) begin
              ctrl[i].per_we   = 1'b1;
              ctrl[i].per_val  = latch_per;
              ctrl[i].run_set  = 1'b1;
              ctrl[i].load_cnt = pair_idle;
            end
          end
          CMD_ALL_OFF: begin
            ctrl[i].stop = 4'(i) < n_live;
          end
          CMD_AMP: begin
            ctrl[i].amp_we  = tgt_ok && ((lo4 == 4'(i)) || (hi4 == 4'(i)));
            ctrl[i].amp_val = amp_w;
          end
          CMD_FREQ: begin
            ctrl[i].freq_we  = tgt_ok && ((lo4 == 4'(i)) || (hi4 == 4'(i)));
            ctrl[i].freq_val = val_q[7:0];
            ctrl[i].per_we   = ctrl[i].freq_we;
            ctrl[i].per_val  = fo_per;
          end
          CMD_OCT: begin
            ctrl[i].oct_we  = tgt_ok && ((lo4 == 4'(i)) || (hi4 == 4'(i)));
            ctrl[i].oct_val = oct_new;
            ctrl[i].per_we  = ctrl[i].oct_we;
            ctrl[i].per_val = fo_per;
          end
          CMD_START: begin
            ctrl[i].run_set  = 4'(i) < n_live;
            ctrl[i].load_cnt = (4'(i) < n_live) && !stat[i].running;
          end
          default: ;
        endcase
      end
    end
  end

  // channels
  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    mcstg_chan #(
      .AMP_RST((g < 2) ? 5'sd8 : 5'sd0)
    ) u_chan (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[g]),
      .stat_o   (stat[g]),
      .held_d_o (held_d[g]),
      .run_d_o  (run_d[g])
    );
  end

  // level sums of the updated state
  mcstg_mix #(
    .CHANNELS(CHANNELS)
  ) u_mix (
    .held_i  (held_d),
    .run_i   (run_d),
    .left_o  (left_d),
    .right_o (right_d),
    .mask_o  (mask_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      left_q  <= left_d;
      right_q <= right_d;
      mask_q  <= mask_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, mask_q, right_q, left_q};

  // checks
  assign stalled      = in_valid_q && out_valid_q && !m_axis_tready;
  assign all_off_step = step && (cmd_q == CMD_ALL_OFF) && (active_q != 4'd0);
  assign level_ok     = (left_q >= -7'sd60) && (left_q <= 7'sd60) &&
                        (right_q >= -7'sd60) && (right_q <= 7'sd60);

  `MCSTG_ASSERT(a_stall_blocks_input, stalled |-> !s_axis_tready, "input taken while full")
  `MCSTG_ASSERT_NEXT(a_step_gives_result, step, out_valid_q, "command passed without a result")
  `MCSTG_ASSERT_NEXT(a_all_off_stops_ch0, all_off_step, !stat[0].running, "channel 0 still on")
  `MCSTG_ASSERT(a_level_range, out_valid_q |-> level_ok, "level sum out of range")

endmodule

`default_nettype wire
